@@ hdl/segment_reassembly_tracker_assert.svh @@
// Assertion macros for the segment reassembly tracker.
// Used by the top level; needs no other file.
`ifndef SEGMENT_REASSEMBLY_TRACKER_ASSERT_SVH
`define SEGMENT_REASSEMBLY_TRACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srt assertion failed");
`define SRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srt assertion failed");
`else
`define SRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/srt_pkg.sv @@
// Shared types and constants of the segment reassembly tracker.
// No dependencies.
package srt_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [7:0] MAX_ERR_RST = 8'd5;

  localparam logic [2:0] KIND_DATA_MORE = 3'd0;
  localparam logic [2:0] KIND_DATA_END  = 3'd1;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_RESEND   = 3'd2,
    ST_ABORT    = 3'd3,
    ST_IGNORED  = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_EXEC
  } back_state_t;

  typedef struct packed {
    logic        is_data;
    logic        is_end;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [31:0] serial;
    logic [31:0] seg;
    logic [15:0] bytes;
    logic [7:0]  chan;
  } job_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [31:0] serial;
    logic [31:0] next_idx;
    logic [31:0] byte_cnt;
    logic [7:0]  err_cnt;
  } row_t;

  typedef struct packed {
    logic busy;
    logic pop;
    logic ram_we;
  } back_stat_t;

endpackage

@@ hdl/srt_ifs.sv @@
// Valid/ready channel interfaces for packet headers and results.
// No dependencies.
interface srt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [63:0] source_id_hi;
  logic [63:0] source_id_lo;
  logic [31:0] msg_serial;
  logic [31:0] segment_index;
  logic [15:0] payload_bytes;
  logic [7:0]  arrival_channel;

  modport source (output valid, req_type, source_id_hi, source_id_lo, msg_serial,
                  segment_index, payload_bytes, arrival_channel, input ready);
  modport sink (input valid, req_type, source_id_hi, source_id_lo, msg_serial,
                segment_index, payload_bytes, arrival_channel, output ready);
endinterface

interface srt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  stream_slot;
  logic [31:0] reply_index;
  logic [31:0] byte_total;
  logic [7:0]  reply_channel;

  modport source (output valid, status, stream_slot, reply_index, byte_total,
                  reply_channel, input ready);
  modport sink (input valid, status, stream_slot, reply_index, byte_total,
                reply_channel, output ready);
endinterface

@@ hdl/srt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/srt_front.sv @@
// Front end: takes packet headers, classifies the kind, queues them.
// Depends on srt_pkg and srt_in_if.
module srt_front (
  input  logic          clk,
  input  logic          rst_n,
  srt_in_if.sink        in_if,
  output srt_pkg::job_t head,
  output logic          head_vld,
  input  logic          pop
);
  import srt_pkg::*;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          q_r [QUEUE_DEPTH];
  logic [QW-1:0] wptr_r, wptr_nxt;
  logic [QW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  job_t          job_in;
  logic          push;

  always_comb begin
    job_in.hi     = in_if.source_id_hi;
    job_in.lo     = in_if.source_id_lo;
    job_in.serial = in_if.msg_serial;
    job_in.seg    = in_if.segment_index;
    job_in.bytes  = in_if.payload_bytes;
    job_in.chan   = in_if.arrival_channel;
    job_in.is_end = (in_if.req_type == KIND_DATA_END);
    unique case (in_if.req_type) inside
      KIND_DATA_MORE, KIND_DATA_END: job_in.is_data = 1'b1;
      default:                       job_in.is_data = 1'b0;
    endcase
  end

  assign in_if.ready = (cnt_r != CW'(QUEUE_DEPTH));
  assign push        = in_if.valid && in_if.ready;
  assign head_vld    = (cnt_r != '0);
  assign head        = q_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= job_in;
    end
  end

endmodule

@@ hdl/srt_back.sv @@
// Back end: scans the stream table, updates the stream, holds the result.
// Depends on srt_pkg, srt_out_if and srt_ram.
module srt_back #(
  parameter int STREAM_SLOTS = srt_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  srt_pkg::job_t       head,
  input  logic                head_vld,
  output logic                pop,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  srt_out_if.source           out_if,
  output srt_pkg::back_stat_t stat
);
  import srt_pkg::*;

  localparam int SLOT_W = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(STREAM_SLOTS + 1);
  localparam int ROW_W  = $bits(row_t);

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic [7:0]  max_err_r;
  logic [STREAM_SLOTS-1:0] valid_r;

  logic [CNT_W-1:0]  iss_r;
  logic              cmp_vld_r;
  logic [SLOT_W-1:0] cmp_addr_r;
  logic              hit_r, free_fnd_r;
  logic [SLOT_W-1:0] hit_slot_r, free_slot_r;
  row_t              row_r;

  logic              rd_en, ram_we, exec_fire, match_now, scan_done;
  logic [SLOT_W-1:0] rd_addr;
  logic [ROW_W-1:0]  rd_data;
  row_t              rd_row;

  logic              out_vld_r;
  status_t           o_status_r, o_status;
  logic [3:0]        o_slot_r, o_slot;
  logic [31:0]       o_index_r, o_index;
  logic [31:0]       o_total_r, o_total;
  logic [7:0]        o_chan_r, o_chan;

  row_t              base, row_new;
  logic [SLOT_W-1:0] wslot;
  logic              have_slot, mism, abort_req;
  logic [7:0]        err_inc;
  logic [32:0]       sum;
  logic [31:0]       sat_sum;

  srt_ram #(.WIDTH(ROW_W), .DEPTH(STREAM_SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wslot),
    .wdata (row_new),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign rd_row    = row_t'(rd_data);
  assign rd_addr   = iss_r[SLOT_W-1:0];
  assign match_now = cmp_vld_r && valid_r[cmp_addr_r] && (rd_row.hi == job_r.hi) &&
                     (rd_row.lo == job_r.lo) && (rd_row.serial == job_r.serial);
  assign scan_done = (iss_r == CNT_W'(STREAM_SLOTS)) && !cmp_vld_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (head_vld) state_nxt = head.is_data ? BK_SCAN : BK_EXEC;
      BK_SCAN: if (match_now || scan_done) state_nxt = BK_EXEC;
      BK_EXEC: if (exec_fire) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop       = 1'b0;
    rd_en     = 1'b0;
    exec_fire = 1'b0;
    unique case (state_r)
      BK_IDLE: pop = head_vld;
      BK_SCAN: rd_en = (iss_r != CNT_W'(STREAM_SLOTS)) && !match_now;
      BK_EXEC: exec_fire = !out_vld_r || out_if.ready;
      default: ;
    endcase
  end

  // stream update
  always_comb begin
    have_slot = hit_r || free_fnd_r;
    wslot     = hit_r ? hit_slot_r : free_slot_r;
    if (hit_r) begin
      base = row_r;
    end else begin
      base          = '0;
      base.hi       = job_r.hi;
      base.lo       = job_r.lo;
      base.serial   = job_r.serial;
    end
    mism      = (job_r.seg != base.next_idx);
    err_inc   = (base.err_cnt != 8'hFF) ? base.err_cnt + 8'd1 : base.err_cnt;
    abort_req = (err_inc > max_err_r);
    sum       = {1'b0, base.byte_cnt} + {17'd0, job_r.bytes};
    sat_sum   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    row_new   = base;
    o_status  = ST_IGNORED;
    o_slot    = '0;
    o_index   = '0;
    o_total   = '0;
    o_chan    = '0;
    if (job_r.is_data && !have_slot) begin
      o_status = ST_FULL;
    end else if (job_r.is_data) begin
      o_slot = 4'(wslot);
      if (mism) begin
        row_new.err_cnt = err_inc;
        o_total         = base.byte_cnt;
        o_chan          = job_r.chan;
        if (abort_req) begin
          o_status = ST_ABORT;
        end else begin
          o_status = ST_RESEND;
          o_index  = base.next_idx;
        end
      end else begin
        row_new.next_idx = base.next_idx + 32'd1;
        row_new.byte_cnt = sat_sum;
        row_new.err_cnt  = '0;
        o_total          = sat_sum;
        o_status         = job_r.is_end ? ST_COMPLETE : ST_ACCEPTED;
      end
    end
  end

  assign ram_we = exec_fire && job_r.is_data && have_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      max_err_r <= MAX_ERR_RST;
      valid_r   <= '0;
      out_vld_r <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        max_err_r <= cfg_wdata;
      end
      if (ram_we) begin
        valid_r[wslot] <= !(!mism && job_r.is_end);
      end
      if (exec_fire) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
      cmp_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r      <= head;
      iss_r      <= '0;
      hit_r      <= 1'b0;
      free_fnd_r <= 1'b0;
    end
    if (rd_en) begin
      iss_r <= iss_r + 1'b1;
    end
    cmp_addr_r <= rd_addr;
    if (state_r == BK_SCAN && match_now) begin
      hit_r      <= 1'b1;
      hit_slot_r <= cmp_addr_r;
      row_r      <= rd_row;
    end
    if (state_r == BK_SCAN && cmp_vld_r && !valid_r[cmp_addr_r] && !free_fnd_r) begin
      free_fnd_r  <= 1'b1;
      free_slot_r <= cmp_addr_r;
    end
    if (exec_fire) begin
      o_status_r <= o_status;
      o_slot_r   <= o_slot;
      o_index_r  <= o_index;
      o_total_r  <= o_total;
      o_chan_r   <= o_chan;
    end
  end

  assign out_if.valid         = out_vld_r;
  assign out_if.status        = 3'(o_status_r);
  assign out_if.stream_slot   = o_slot_r;
  assign out_if.reply_index   = o_index_r;
  assign out_if.byte_total    = o_total_r;
  assign out_if.reply_channel = o_chan_r;

  assign stat.busy   = (state_r != BK_IDLE);
  assign stat.pop    = pop;
  assign stat.ram_we = ram_we;

endmodule

@@ hdl/segment_reassembly_tracker.sv @@
// Flow: a data item's result follows acceptance through queue pop, one RAM read per slot,
// compare and scan-end steps and result load; a hit ends the scan early.
// A non-data item's result follows acceptance through queue pop and result load.
// One item in the back end at a time, so no new item is popped before the last result is loaded;
// a two-entry queue takes items meanwhile; a stalled result holds.
// Reset: synchronous active-low; clears slot valid bits, queue, result, max_errors to 5.
module segment_reassembly_tracker #(
  parameter int STREAM_SLOTS = srt_pkg::SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  srt_in_if.sink     in_if,
  srt_out_if.source  out_if,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import srt_pkg::*;

`include "segment_reassembly_tracker_assert.svh"

  job_t       head;
  logic       head_vld;
  logic       pop;
  back_stat_t bk_stat;

  srt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .head     (head),
    .head_vld (head_vld),
    .pop      (pop)
  );

  srt_back #(.STREAM_SLOTS(STREAM_SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_vld  (head_vld),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_if    (out_if),
    .stat      (bk_stat)
  );

  `SRT_ASSERT_IMP(a_void_result_zero, clk, rst_n, out_if.valid && (out_if.status == 3'(ST_IGNORED) || out_if.status == 3'(ST_FULL)), out_if.stream_slot == '0 && out_if.byte_total == '0 && out_if.reply_channel == '0 && out_if.reply_index == '0)
  `SRT_ASSERT_IMP(a_index_only_resend, clk, rst_n, out_if.valid && out_if.status != 3'(ST_RESEND), out_if.reply_index == '0)
  `SRT_ASSERT_IMP(a_pop_not_write, clk, rst_n, bk_stat.pop, !bk_stat.ram_we)
  `SRT_ASSERT_NXT(a_pop_busy, clk, rst_n, bk_stat.pop, bk_stat.busy)

endmodule

@@ bench/segment_reassembly_tracker_checker.sv @@
// Reply checker for the segment reassembly tracker: keeps its own stream table,
// predicts one reply per accepted header and compares it with the block's output.
// Depends on srt_pkg and the srt_in_if / srt_out_if interfaces.
module segment_reassembly_tracker_checker (
  input  logic       clk,
  input  logic       rst_n,
  srt_in_if          in_ch,
  srt_out_if         out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  output int         fail_count,
  output int         outstanding,
  output int         checked_count
);
  import srt_pkg::*;

  localparam int FIFO_DEPTH = 64;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [31:0] serial;
    logic [31:0] seg;
    logic [15:0] bytes;
    logic [7:0]  chan;
  } header_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  slot;
    logic [31:0] index;
    logic [31:0] total;
    logic [7:0]  chan;
  } reply_t;

  logic        live       [SLOTS_DEF];
  logic [63:0] key_hi     [SLOTS_DEF];
  logic [63:0] key_lo     [SLOTS_DEF];
  logic [31:0] key_serial [SLOTS_DEF];
  logic [31:0] next_seg   [SLOTS_DEF];
  logic [31:0] rx_bytes   [SLOTS_DEF];
  logic [7:0]  miss_count [SLOTS_DEF];
  logic [7:0]  err_limit;
  reply_t      reply_fifo [FIFO_DEPTH];
  int          fifo_wr;
  int          fifo_rd;

  function automatic reply_t predict_reply(input header_t h);
    reply_t      r;
    int          s;
    logic [32:0] sum;
    r = '0;
    if (h.kind != KIND_DATA_MORE && h.kind != KIND_DATA_END) begin
      r.status = ST_IGNORED;
      return r;
    end
    s = -1;
    for (int i = 0; i < SLOTS_DEF; i++)
      if (s < 0 && live[i] && key_hi[i] == h.hi && key_lo[i] == h.lo &&
          key_serial[i] == h.serial)
        s = i;
    if (s < 0) begin
      for (int i = SLOTS_DEF - 1; i >= 0; i--)
        if (!live[i]) s = i;
      if (s < 0) begin
        r.status = ST_FULL;
        return r;
      end
      live[s]       = 1'b1;
      key_hi[s]     = h.hi;
      key_lo[s]     = h.lo;
      key_serial[s] = h.serial;
      next_seg[s]   = '0;
      rx_bytes[s]   = '0;
      miss_count[s] = '0;
    end
    r.slot = s[3:0];
    if (h.seg != next_seg[s]) begin
      if (miss_count[s] != 8'hFF) miss_count[s] = miss_count[s] + 8'd1;
      r.total = rx_bytes[s];
      r.chan  = h.chan;
      if (miss_count[s] > err_limit) begin
        r.status = ST_ABORT;
      end else begin
        r.status = ST_RESEND;
        r.index  = next_seg[s];
      end
      return r;
    end
    next_seg[s]   = next_seg[s] + 32'd1;
    sum           = {1'b0, rx_bytes[s]} + {17'd0, h.bytes};
    rx_bytes[s]   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    miss_count[s] = '0;
    r.total       = rx_bytes[s];
    if (h.kind == KIND_DATA_END) begin
      r.status = ST_COMPLETE;
      live[s]  = 1'b0;
    end else begin
      r.status = ST_ACCEPTED;
    end
    return r;
  endfunction

  function automatic int field_differs(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    header_t h;
    reply_t  want;
    int      bad;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS_DEF; i++) live[i] = 1'b0;
      err_limit = MAX_ERR_RST;
      fifo_wr   = 0;
      fifo_rd   = 0;
      fail_count    = 0;
      outstanding   = 0;
      checked_count = 0;
    end else begin
      if (cfg_we) err_limit = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        h.kind   = in_ch.req_type;
        h.hi     = in_ch.source_id_hi;
        h.lo     = in_ch.source_id_lo;
        h.serial = in_ch.msg_serial;
        h.seg    = in_ch.segment_index;
        h.bytes  = in_ch.payload_bytes;
        h.chan   = in_ch.arrival_channel;
        reply_fifo[fifo_wr[5:0]] = predict_reply(h);
        fifo_wr++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (fifo_wr == fifo_rd) begin
          $error("reply with no header waiting: status %0d", out_ch.status);
          fail_count++;
        end else begin
          want = reply_fifo[fifo_rd[5:0]];
          fifo_rd++;
          bad  = field_differs("status", 32'(want.status), 32'(out_ch.status)) +
                 field_differs("stream_slot", 32'(want.slot), 32'(out_ch.stream_slot)) +
                 field_differs("reply_index", want.index, out_ch.reply_index) +
                 field_differs("byte_total", want.total, out_ch.byte_total) +
                 field_differs("reply_channel", 32'(want.chan), 32'(out_ch.reply_channel));
          if (bad != 0) fail_count++;
          checked_count++;
        end
      end
      outstanding = fifo_wr - fifo_rd;
    end
  end

endmodule

@@ bench/segment_reassembly_tracker_test.sv @@
// Testbench top for the segment reassembly tracker: clock, reset, header stimulus
// with random gaps, random reply stalls, max_errors updates and the verdict.
// Depends on srt_pkg, the srt interfaces, the block and its reply checker.
module segment_reassembly_tracker_test;
  import srt_pkg::*;

  localparam logic [2:0] KIND_RESEND = 3'd2;  // first non-data kind
  localparam int KIND_CODES    = 8;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 2 * SLOTS_DEF + 8;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  int         fail_count;
  int         outstanding;
  int         checked_count;
  int         cycle_count  = 0;
  int         headers_sent = 0;
  int         limits_set   = 0;
  int         full_tries   = 0;
  bit         send_idles   = 1'b1;
  bit         sink_idles   = 1'b1;
  int         miss_pct     = 20;

  // sender-side view of open streams
  logic [63:0] pool_hi     [SLOTS_DEF];
  logic [63:0] pool_lo     [SLOTS_DEF];
  logic [31:0] pool_serial [SLOTS_DEF];
  logic [31:0] pool_next   [SLOTS_DEF];
  int          pool_size = 0;

  srt_in_if  in_ch ();
  srt_out_if out_ch ();

  segment_reassembly_tracker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  segment_reassembly_tracker_checker i_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [15:0] rand_bytes();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] wrong_seg(input logic [31:0] want);
    logic [31:0] s;
    do begin
      case ($urandom_range(0, 2))
        0:       s = want + $urandom_range(1, 4);
        1:       s = want - $urandom_range(1, 2);
        default: s = $urandom;
      endcase
    end while (s == want);
    return s;
  endfunction

  initial begin : reply_sink
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if (sink_idles && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  task automatic push_header(input logic [2:0] kind, input logic [63:0] hi,
                             input logic [63:0] lo, input logic [31:0] serial,
                             input logic [31:0] seg, input logic [15:0] bytes,
                             input logic [7:0] chan);
    int gap;
    gap = send_idles ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid           <= 1'b1;
    in_ch.req_type        <= kind;
    in_ch.source_id_hi    <= hi;
    in_ch.source_id_lo    <= lo;
    in_ch.msg_serial      <= serial;
    in_ch.segment_index   <= seg;
    in_ch.payload_bytes   <= bytes;
    in_ch.arrival_channel <= chan;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    headers_sent++;
  endtask

  task automatic drain_replies();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (outstanding == 0);
  endtask

  task automatic set_error_limit(input logic [7:0] value);
    drain_replies();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    limits_set++;
  endtask

  task automatic stream_step(input int idx);
    logic [2:0]  kind;
    logic [31:0] seg;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [31:0] serial;
    kind   = ($urandom_range(0, 5) == 0) ? KIND_DATA_END : KIND_DATA_MORE;
    hi     = pool_hi[idx];
    lo     = pool_lo[idx];
    serial = pool_serial[idx];
    if ($urandom_range(0, 99) < miss_pct) begin
      seg = wrong_seg(pool_next[idx]);
    end else begin
      seg            = pool_next[idx];
      pool_next[idx] = seg + 32'd1;
      if (kind == KIND_DATA_END) begin
        pool_size--;
        pool_hi[idx]     = pool_hi[pool_size];
        pool_lo[idx]     = pool_lo[pool_size];
        pool_serial[idx] = pool_serial[pool_size];
        pool_next[idx]   = pool_next[pool_size];
      end
    end
    push_header(kind, hi, lo, serial, seg, rand_bytes(), 8'($urandom));
  endtask

  task automatic open_stream();
    logic [2:0]  kind;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [31:0] serial;
    logic [31:0] seg;
    bit          taken;
    int          j;
    do begin
      if (pool_size > 0 && $urandom_range(0, 2) == 0) begin
        // near neighbor of an open stream: one key bit apart
        j      = $urandom_range(0, pool_size - 1);
        hi     = pool_hi[j];
        lo     = pool_lo[j];
        serial = pool_serial[j];
        case ($urandom_range(0, 2))
          0:       hi ^= 64'd1 << $urandom_range(0, 63);
          1:       lo ^= 64'd1 << $urandom_range(0, 63);
          default: serial ^= 32'd1 << $urandom_range(0, 31);
        endcase
      end else begin
        hi     = {$urandom, $urandom};
        lo     = {$urandom, $urandom};
        serial = $urandom;
      end
      taken = 1'b0;
      for (int i = 0; i < pool_size; i++)
        if (pool_hi[i] == hi && pool_lo[i] == lo && pool_serial[i] == serial) taken = 1'b1;
    end while (taken);
    kind = ($urandom_range(0, 9) == 0) ? KIND_DATA_END : KIND_DATA_MORE;
    seg  = ($urandom_range(0, 4) == 0) ? wrong_seg(32'd0) : 32'd0;
    if (pool_size == SLOTS_DEF) begin
      full_tries++;
    end else if (!(seg == 32'd0 && kind == KIND_DATA_END)) begin
      pool_hi[pool_size]     = hi;
      pool_lo[pool_size]     = lo;
      pool_serial[pool_size] = serial;
      pool_next[pool_size]   = (seg == 32'd0) ? 32'd1 : 32'd0;
      pool_size++;
    end
    push_header(kind, hi, lo, serial, seg, rand_bytes(), 8'($urandom));
  endtask

  task automatic random_traffic(input int count, input int pool_target);
    int roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 8)
        push_header(3'($urandom_range(KIND_RESEND, KIND_CODES - 1)),
                    {$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom,
                    16'($urandom), 8'($urandom));
      else if (pool_size > 0 && (pool_size >= pool_target || roll < 70))
        stream_step($urandom_range(0, pool_size - 1));
      else
        open_stream();
    end
  endtask

  initial begin : stimulus
    logic [63:0] base_hi;
    logic [63:0] base_lo;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    in_ch.valid           = 1'b0;
    in_ch.req_type        = '0;
    in_ch.source_id_hi    = '0;
    in_ch.source_id_lo    = '0;
    in_ch.msg_serial      = '0;
    in_ch.segment_index   = '0;
    in_ch.payload_bytes   = '0;
    in_ch.arrival_channel = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // non-data kinds, including the unused codes
    for (int k = KIND_RESEND; k < KIND_CODES; k++)
      push_header(3'(k), {64{k[0]}}, {64{k[0]}}, {32{k[0]}}, {32{k[0]}}, {16{k[0]}},
                  {8{k[0]}});
    push_header(KIND_DATA_MORE, '1, '1, '1, 32'd0, 16'hFFFF, 8'hFF);
    push_header(KIND_DATA_MORE, '0, '0, '0, 32'd7, 16'd9, 8'd0);
    push_header(KIND_DATA_END, '1, '1, '1, 32'd9, 16'd5, 8'h81);
    push_header(KIND_DATA_MORE, '0, '0, '0, 32'd0, 16'd0, 8'd3);
    push_header(KIND_DATA_END, '1, '1, '1, 32'd1, 16'hFFFF, 8'd1);
    push_header(KIND_DATA_END, '1, '0, '0, 32'd0, 16'd1, 8'd2);
    push_header(KIND_DATA_MORE, '0, '1, '1, 32'hFFFF_FFFF, 16'd4, 8'h7E);
    push_header(KIND_DATA_END, '0, '1, '1, 32'd0, 16'd4, 8'h7E);
    push_header(KIND_DATA_END, '0, '0, '0, 32'd1, 16'd100, 8'd3);

    // fill the table, one refused open, then close every stream
    base_hi = {$urandom, $urandom};
    base_lo = {$urandom, $urandom};
    for (int i = 0; i <= SLOTS_DEF; i++)
      push_header(KIND_DATA_MORE, base_hi, base_lo, i, 32'd0, rand_bytes(), 8'($urandom));
    full_tries++;
    for (int i = 0; i < SLOTS_DEF; i++)
      push_header(KIND_DATA_END, base_hi, base_lo, i, 32'd1, rand_bytes(), 8'($urandom));

    // zero tolerance: first mismatch aborts, stream stays open
    set_error_limit(8'd0);
    base_hi = {$urandom, $urandom};
    push_header(KIND_DATA_MORE, base_hi, base_lo, 32'd5, 32'd0, 16'd10, 8'd1);
    push_header(KIND_DATA_MORE, base_hi, base_lo, 32'd5, 32'd3, 16'd10, 8'd2);
    push_header(KIND_DATA_END, base_hi, base_lo, 32'd5, 32'd1, 16'd10, 8'd3);

    // mismatch count saturates at its top value
    set_error_limit(8'hFF);
    base_hi = {$urandom, $urandom};
    push_header(KIND_DATA_MORE, base_hi, base_lo, 32'd9, 32'd0, rand_bytes(), 8'd4);
    repeat (258)
      push_header(KIND_DATA_MORE, base_hi, base_lo, 32'd9, wrong_seg(32'd1), rand_bytes(),
                  8'($urandom));
    set_error_limit(8'hFE);
    push_header(KIND_DATA_END, base_hi, base_lo, 32'd9, wrong_seg(32'd1), 16'd7, 8'd5);
    push_header(KIND_DATA_END, base_hi, base_lo, 32'd9, 32'd1, 16'd7, 8'd6);

    set_error_limit(8'd1);
    miss_pct = 35;
    random_traffic(350, 6);

    set_error_limit(8'($urandom_range(2, 253)));
    sink_idles = 1'b0;
    miss_pct   = 20;
    random_traffic(350, 17);

    set_error_limit(8'd3);
    sink_idles = 1'b1;
    send_idles = 1'b0;
    miss_pct   = 40;
    random_traffic(350, 17);

    set_error_limit(8'hFF);
    sink_idles = 1'b0;
    miss_pct   = 15;
    random_traffic(250, 12);

    set_error_limit(8'd0);
    sink_idles = 1'b1;
    send_idles = 1'b1;
    miss_pct   = 25;
    random_traffic(200, 17);

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d headers and %0d checked replies over %0d max_errors writes,",
             headers_sent, checked_count, limits_set);
    $display("with %0d opens refused on a full stream table.", full_tries);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
